// ===== src/fixed_weight_position_picker_defines.svh =====
// ----------------------------------------------------------------------------
// Fixed weight position picker: assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_WEIGHT_POSITION_PICKER_DEFINES_SVH
`define FIXED_WEIGHT_POSITION_PICKER_DEFINES_SVH

// same-cycle implication
`define FWPP_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FWPP_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fwpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed weight position picker: package
// Field widths, register map, reset values and shared types.
// ----------------------------------------------------------------------------
package fwpp_pkg;

  localparam int WORD_W    = 16;
  localparam int STEP_W    = $clog2(WORD_W + 1);
  localparam int POS_W     = 13;
  localparam int TDATA_W   = 16;
  localparam int CODE_W    = 14;
  localparam int TARGET_W  = 8;
  localparam int SPARE_W   = 8;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [CODE_W-1:0]   CODE_LENGTH_RST   = 14'd6688;
  localparam logic [TARGET_W-1:0] TARGET_WEIGHT_RST = 8'd128;
  localparam logic [SPARE_W-1:0]  SPARE_WORDS_RST   = 8'd10;

  // register index (byte address bits [3:2])
  localparam logic [1:0] REG_CODE_LENGTH   = 2'd0;
  localparam logic [1:0] REG_TARGET_WEIGHT = 2'd1;
  localparam logic [1:0] REG_SPARE_WORDS   = 2'd2;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

// ===== src/fixed_weight_position_picker.sv =====
// ----------------------------------------------------------------------------
// Fixed weight position picker
// Picks distinct error positions from a stream of random words.
// ----------------------------------------------------------------------------
// Input beats carry a 16-bit random word in s_tdata and a start flag in
// s_tuser; a start clears the kept set and opens a new selection with that
// word. Each word is reduced modulo code_length (MAX_LENGTH if 0 or over it),
// checked against the positions kept so far, and kept if new. One output beat
// per input beat: m_tdata holds the position, m_tuser the accepted, done and
// failed flags. Words that arrive while no selection is open still give a
// position, with all flags low.
// One beat at a time. Each word runs through the bit-serial remainder, the
// scan of the kept positions, eval and the output load; the scan is skipped at
// a met target, and with no open selection the remainder goes straight to the
// output load. A finished result sits in the output register; the next word
// is taken the cycle after the load, also while it waits, and the block stalls
// before loading its next result until the receiver drains it.
// Reset: registers back to defaults, no selection open, output empty.
// Registers (APB, byte address 4*i): code_length, target_weight, spare_words.
// Write registers only while the block is idle.
// ----------------------------------------------------------------------------
module fixed_weight_position_picker
  import fwpp_pkg::*;
#(
  parameter int MAX_WEIGHT = 128,
  parameter int MAX_LENGTH = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [15:0] random_word
  input  logic [0:0]         s_tuser,   // [0] start_vector
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [12:0] position, [15:13] zero
  output logic [2:0]         m_tuser,   // [0] accepted, [1] vector_done, [2] vector_failed
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int CW = $clog2(MAX_WEIGHT + 1);
  localparam int AW = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;
  localparam int BW = $clog2(MAX_WEIGHT + 256);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [CODE_W-1:0]   code_length;
  logic [TARGET_W-1:0] target_weight;
  logic [SPARE_W-1:0]  spare_words;

  logic [LW-1:0] n_eff;
  logic [CW-1:0] t_eff;
  logic [BW-1:0] budget;

  logic [2:0]    state;
  logic [LW-1:0] pos_r;
  logic          acc_r;
  logic          done_r;
  logic          fail_r;
  logic [CW-1:0] kept_count;
  logic [BW-1:0] words_used;
  logic          over;

  logic          accept;
  logic          div_done;
  logic [LW-1:0] div_rem;
  logic          scan_start;
  scan_rsp_t     scan_rsp;
  logic          wr_en;

  logic [POS_W-1:0] out_pos;
  logic [2:0]       out_flags;

  // ---- configuration port ----
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length   <= CODE_LENGTH_RST;
      target_weight <= TARGET_WEIGHT_RST;
      spare_words   <= SPARE_WORDS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_CODE_LENGTH:   code_length   <= pwdata[CODE_W-1:0];
        REG_TARGET_WEIGHT: target_weight <= pwdata[TARGET_W-1:0];
        REG_SPARE_WORDS:   spare_words   <= pwdata[SPARE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CODE_LENGTH:   prdata = APB_DW'(code_length);
      REG_TARGET_WEIGHT: prdata = APB_DW'(target_weight);
      REG_SPARE_WORDS:   prdata = APB_DW'(spare_words);
      default:           prdata = '0;
    endcase
  end

  // ---- effective limits ----
  always_comb begin
    if ((code_length == '0) || (32'(code_length) > MAX_LENGTH)) begin
      n_eff = LW'(MAX_LENGTH);
    end else begin
      n_eff = LW'(code_length);
    end
    if (32'(target_weight) > MAX_WEIGHT) begin
      t_eff = CW'(MAX_WEIGHT);
    end else begin
      t_eff = CW'(target_weight);
    end
    budget = BW'(t_eff) + BW'(spare_words);
  end

  // ---- control ----
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign scan_start = (state == ST_DIV) && div_done && !over && (kept_count < t_eff);
  assign wr_en      = (state == ST_SCAN) && scan_rsp.done && !scan_rsp.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      kept_count <= '0;
      words_used <= '0;
      over       <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser[0]) begin
              kept_count <= '0;
              words_used <= '0;
              over       <= 1'b0;
            end
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (over) begin
              state <= ST_OUT;
            end else begin
              words_used <= words_used + 1'b1;
              state      <= (kept_count < t_eff) ? ST_SCAN : ST_EVAL;
            end
          end
        end
        ST_SCAN: begin
          if (scan_rsp.done) begin
            if (!scan_rsp.hit) begin
              kept_count <= kept_count + 1'b1;
            end
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if ((kept_count >= t_eff) || (words_used >= budget)) begin
            over <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-beat result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r  <= 1'b0;
      done_r <= 1'b0;
      fail_r <= 1'b0;
    end
    if ((state == ST_DIV) && div_done) begin
      pos_r <= div_rem;
    end
    if (wr_en) begin
      acc_r <= 1'b1;
    end
    if (state == ST_EVAL) begin
      if (kept_count >= t_eff) begin
        done_r <= 1'b1;
      end else if (words_used >= budget) begin
        fail_r <= 1'b1;
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
      out_pos   <= POS_W'(pos_r);
      out_flags <= {fail_r, done_r, acc_r};
    end
  end

  assign m_tdata = TDATA_W'(out_pos);
  assign m_tuser = out_flags;

  // ---- datapath units ----
  fwpp_mod #(
    .LW (LW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .word    (s_tdata[WORD_W-1:0]),
    .modulus (n_eff),
    .done    (div_done),
    .rem     (div_rem)
  );

  fwpp_kept #(
    .DEPTH (MAX_WEIGHT),
    .LW    (LW),
    .CW    (CW),
    .AW    (AW)
  ) u_kept (
    .clk        (clk),
    .rst        (rst),
    .scan_start (scan_start),
    .scan_pos   (div_rem),
    .scan_count (kept_count),
    .scan_rsp   (scan_rsp),
    .wr_en      (wr_en),
    .wr_addr    (kept_count[AW-1:0]),
    .wr_data    (pos_r)
  );

endmodule

// ===== src/fwpp_mod.sv =====
// ----------------------------------------------------------------------------
// Fixed weight position picker: modulo unit
// Restoring remainder of a 16-bit word by a run-time modulus, one bit a cycle.
// ----------------------------------------------------------------------------
module fwpp_mod
  import fwpp_pkg::*;
#(
  parameter int LW = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] word,
  input  logic [LW-1:0]     modulus,
  output logic              done,
  output logic [LW-1:0]     rem
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [WORD_W-1:0] dividend;
  logic [LW-1:0]     modulus_r;
  logic [LW:0]       shifted;
  logic [LW:0]       reduced;

  always_comb begin
    shifted = {rem, dividend[WORD_W-1]};
    if (shifted >= {1'b0, modulus_r}) begin
      reduced = shifted - {1'b0, modulus_r};
    end else begin
      reduced = shifted;
    end
  end

  assign done = busy && (step == STEP_W'(WORD_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend  <= word;
      modulus_r <= modulus;
      rem       <= '0;
    end else if (busy && !done) begin
      dividend <= {dividend[WORD_W-2:0], 1'b0};
      rem      <= reduced[LW-1:0];
    end
  end

endmodule

// ===== src/fwpp_kept.sv =====
// ----------------------------------------------------------------------------
// Fixed weight position picker: kept position store
// Synchronous memory of kept positions with a sequential duplicate scan.
// ----------------------------------------------------------------------------
module fwpp_kept
  import fwpp_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int LW    = 14,
  parameter int CW    = 8,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          scan_start,
  input  logic [LW-1:0] scan_pos,
  input  logic [CW-1:0] scan_count,
  output scan_rsp_t     scan_rsp,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [LW-1:0] wr_data
);

  logic [LW-1:0] mem [DEPTH];
  logic [LW-1:0] rd_data;
  logic [LW-1:0] pos_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx;
  logic          active;
  logic          pending;
  logic          hit;
  logic          issue;

  assign issue         = active && (idx != count_r);
  assign scan_rsp.done = active && (idx == count_r) && !pending;
  assign scan_rsp.hit  = hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      pending <= 1'b0;
      hit     <= 1'b0;
      idx     <= '0;
    end else if (scan_start) begin
      active  <= 1'b1;
      pending <= 1'b0;
      hit     <= 1'b0;
      idx     <= '0;
    end else if (active) begin
      pending <= issue;
      if (issue) begin
        idx <= idx + 1'b1;
      end
      if (pending && (rd_data == pos_r)) begin
        hit <= 1'b1;
      end
      if (scan_rsp.done) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      pos_r   <= scan_pos;
      count_r <= scan_count;
    end
  end

endmodule

// ===== src/fwpp_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed weight position picker: port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_weight_position_picker_defines.svh"

module fwpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        pready
);

  `FWPP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed while stalled")

  `FWPP_ASSERT_NOW(a_done_fail_excl, clk, rst, m_tvalid, !(m_tuser[1] && m_tuser[2]), "done and failed on the same beat")

  `FWPP_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")

  `FWPP_ASSERT_NOW(a_pready_high, clk, rst, 1'b1, pready, "pready dropped")

endmodule

bind fixed_weight_position_picker fwpp_checker u_fwpp_checker (.*);
